### hdl/cect_pkg.sv
// Shared types, codes and constants of the encoder command tracker.
// No dependencies; every other file imports this package.
package cect_pkg;

  localparam int NUM_COMMANDS = 13;
  localparam int CODE_MAX     = (NUM_COMMANDS < 13) ? NUM_COMMANDS : 13;
  localparam int IDX_W        = $clog2(NUM_COMMANDS);

  // operations
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // command status
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_ACKED   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  // wire command codes
  localparam logic [3:0] CMD_READ_ANGLE  = 4'd1;
  localparam logic [3:0] CMD_SET_ID      = 4'd2;
  localparam logic [3:0] CMD_SET_BAUD    = 4'd3;
  localparam logic [3:0] CMD_SET_MODE    = 4'd4;
  localparam logic [3:0] CMD_SET_RX_TIME = 4'd5;
  localparam logic [3:0] CMD_SET_ZERO    = 4'd6;
  localparam logic [3:0] CMD_SET_DIR     = 4'd7;
  localparam logic [3:0] CMD_READ_MULTI  = 4'd8;
  localparam logic [3:0] CMD_READ_TURN   = 4'd9;
  localparam logic [3:0] CMD_READ_SPEED  = 4'd10;
  localparam logic [3:0] CMD_SET_SAMPLE  = 4'd11;
  localparam logic [3:0] CMD_SET_MID     = 4'd12;
  localparam logic [3:0] CMD_SET_VALUE   = 4'd13;

  // configuration register indexes
  localparam logic [1:0] CFG_OFFLINE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_REPLY_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_INITIAL_ID    = 2'd2;

  localparam logic [15:0] OFFLINE_LIMIT_RST = 16'd100;
  localparam logic [7:0]  REPLY_TIMEOUT_RST = 8'd100;
  localparam logic [7:0]  DEVICE_ID_RST     = 8'd1;

  localparam logic [31:0] MULTI_WRAP_LIMIT = 32'd1073741823;
  localparam logic [31:0] MULTI_WRAP_SUB   = 32'd2147483647;
  localparam logic [31:0] TURN_WRAP_LIMIT  = 32'd262143;
  localparam logic [19:0] TURN_WRAP_SUB    = 20'd524287;
  localparam logic [31:0] TURN_SAT_LIMIT   = 32'd1048574;
  localparam logic [19:0] TURN_MAX         = 20'd524287;
  localparam logic [7:0]  MODE_HIGH_BYTE   = 8'hAA;
  localparam logic [15:0] RX_TIME_MIN      = 16'd50;
  localparam logic [7:0]  LEN_SHORT        = 8'h04;
  localparam logic [7:0]  LEN_MID          = 8'h05;
  localparam logic [7:0]  LEN_LONG         = 8'h07;
  localparam logic [7:0]  FRAME_TAG        = 8'h01;

  // classified item passed from the front to the back
  typedef struct packed {
    logic [1:0]       op;
    logic             code_ok;
    logic [IDX_W-1:0] idx;
    logic [3:0]       code;
    logic             is_read;
    logic [63:0]      frame;
    logic [7:0]       rid;
    logic [31:0]      value;
    logic             pay_ok;
  } cmd_t;

  typedef struct packed {
    logic        send_valid;
    logic [63:0] tx_frame;
    logic [7:0]  tx_can_id;
    logic [1:0]  command_status;
    logic [15:0] angle_count;
    logic [31:0] multi_turn_position;
    logic [19:0] turn_count;
    logic [31:0] speed_word;
    logic        online;
  } res_t;

endpackage

### hdl/cect_front.sv
// Front end: classifies an incoming request, builds its frame and decodes reply words.
// Depends on cect_pkg.
module cect_front import cect_pkg::*; (
  input  logic [1:0]  operation_i,
  input  logic [3:0]  command_code_i,
  input  logic [15:0] argument_i,
  input  logic [7:0]  reply_id_i,
  input  logic [7:0]  reply_code_i,
  input  logic [31:0] reply_payload_i,
  output cmd_t        cmd_o
);

  logic [3:0]  code;
  logic        code_ok;
  logic [7:0]  len;
  logic [7:0]  b3, b4, b5, b6;
  logic [31:0] value;

  always_comb begin
    if (operation_i == OP_REPLY) begin
      code    = reply_code_i[3:0];
      code_ok = (reply_code_i >= 8'd1) && (reply_code_i <= 8'(CODE_MAX));
    end else begin
      code    = command_code_i;
      code_ok = (command_code_i >= 4'd1) && (command_code_i <= 4'(CODE_MAX));
    end
  end

  // frame arguments, clamped per command
  always_comb begin
    len = LEN_SHORT;
    b3  = 8'd0;
    b4  = 8'd0;
    b5  = 8'd0;
    b6  = 8'd0;
    unique case (command_code_i)
      CMD_SET_ID: begin
        if (argument_i == 16'd0) b3 = 8'd1;
        else if (argument_i > 16'd255) b3 = 8'd255;
        else b3 = argument_i[7:0];
      end
      CMD_SET_BAUD: begin
        b3 = (argument_i > 16'd4) ? 8'd4 : argument_i[7:0];
      end
      CMD_SET_MODE: begin
        if (argument_i == 16'd0) b3 = 8'd0;
        else if (argument_i == 16'd1) b3 = 8'd1;
        else b3 = MODE_HIGH_BYTE;
      end
      CMD_SET_RX_TIME: begin
        len = LEN_MID;
        if (argument_i < RX_TIME_MIN) begin
          b3 = RX_TIME_MIN[7:0];
          b4 = RX_TIME_MIN[15:8];
        end else begin
          b3 = argument_i[7:0];
          b4 = argument_i[15:8];
        end
      end
      CMD_SET_DIR: begin
        b3 = (argument_i > 16'd255) ? 8'd255 : argument_i[7:0];
      end
      CMD_SET_SAMPLE: begin
        len = LEN_MID;
        b3  = argument_i[7:0];
        b4  = argument_i[15:8];
      end
      CMD_SET_VALUE: begin
        len = LEN_LONG;
        b5  = argument_i[15:8];
        b6  = argument_i[7:0];
      end
      default: begin
      end
    endcase
  end

  // reply word decoding
  always_comb begin
    value = reply_payload_i;
    unique case (code)
      CMD_READ_ANGLE: value = {16'd0, reply_payload_i[15:0]};
      CMD_READ_MULTI: begin
        if (reply_payload_i > MULTI_WRAP_LIMIT) value = reply_payload_i - MULTI_WRAP_SUB;
      end
      CMD_READ_TURN: begin
        if (reply_payload_i > TURN_SAT_LIMIT) value = {12'd0, TURN_MAX};
        else if (reply_payload_i > TURN_WRAP_LIMIT)
          value = {12'd0, reply_payload_i[19:0] - TURN_WRAP_SUB};
        else value = reply_payload_i;
      end
      default: value = reply_payload_i;
    endcase
  end

  always_comb begin
    cmd_o.op      = operation_i;
    cmd_o.code_ok = code_ok;
    cmd_o.idx     = IDX_W'(code - 4'd1);
    cmd_o.code    = code;
    cmd_o.is_read = (code == CMD_READ_ANGLE) || (code == CMD_READ_MULTI) ||
                    (code == CMD_READ_TURN) || (code == CMD_READ_SPEED);
    cmd_o.frame   = {8'd0, b6, b5, b4, b3, {4'd0, command_code_i}, FRAME_TAG, len};
    cmd_o.rid     = reply_id_i;
    cmd_o.value   = value;
    cmd_o.pay_ok  = (reply_payload_i[7:0] == 8'd0);
  end

endmodule

### hdl/cect_cmd_fifo.sv
// Two-entry queue of classified requests between the front and the back.
// Depends on cect_pkg.
module cect_cmd_fifo import cect_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

### hdl/cect_back.sv
// Back end: command status table, timeout counters, decoded values, watchdog,
// configuration registers and the two-entry result queue. Depends on cect_pkg.
module cect_back import cect_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  cmd_t        cmd_i,
  input  logic        cmd_empty_i,
  output logic        cmd_pop_o,
  output res_t        res_o,
  output logic        empty_o,
  input  logic        pop_i
);

  logic [1:0]  status_q [NUM_COMMANDS];
  logic [1:0]  status_d [NUM_COMMANDS];
  logic [7:0]  tmo_q    [NUM_COMMANDS];
  logic [7:0]  tmo_d    [NUM_COMMANDS];
  logic [15:0] offline_limit_q;
  logic [7:0]  reply_timeout_q;
  logic [7:0]  req_id_q, req_id_d;
  logic [7:0]  cur_id_q, cur_id_d;
  logic [15:0] angle_q, angle_d;
  logic [31:0] pos_q, pos_d;
  logic [19:0] turn_q, turn_d;
  logic [31:0] speed_q, speed_d;
  logic [15:0] silence_q, silence_d;
  logic        online_q, online_d;
  logic [7:0]  cfg_id;

  res_t        res_q [2];
  res_t        res_d;
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        exec, do_pop;

  logic [1:0]  st;
  logic [7:0]  tc_inc;
  logic [16:0] silence_inc;
  logic        go;
  logic [1:0]  new_st;

  assign exec      = !cmd_empty_i && (cnt_q != 2'd2);
  assign cmd_pop_o = exec;
  assign do_pop    = pop_i && (cnt_q != 2'd0);
  assign empty_o   = (cnt_q == 2'd0);
  assign res_o     = res_q[rd_ptr_q];

  assign st          = status_q[cmd_i.idx];
  assign tc_inc      = tmo_q[cmd_i.idx] + 8'd1;
  assign silence_inc = {1'b0, silence_q} + 17'd1;
  assign go          = cmd_i.is_read ? (st != ST_PENDING) : (st == ST_IDLE);
  assign cfg_id      = (cfg_data_i[7:0] == 8'd0) ? 8'd1 : cfg_data_i[7:0];

  always_comb begin
    status_d  = status_q;
    tmo_d     = tmo_q;
    req_id_d  = req_id_q;
    cur_id_d  = cur_id_q;
    angle_d   = angle_q;
    pos_d     = pos_q;
    turn_d    = turn_q;
    speed_d   = speed_q;
    silence_d = silence_q;
    online_d  = online_q;
    new_st    = ST_IDLE;
    res_d.send_valid = 1'b0;
    res_d.tx_frame   = 64'd0;

    if (exec) begin
      unique case (cmd_i.op)
        OP_REQUEST: begin
          if (cmd_i.code_ok) begin
            new_st = st;
            if (go) begin
              new_st           = ST_PENDING;
              res_d.send_valid = 1'b1;
              res_d.tx_frame   = cmd_i.frame;
              if (cmd_i.code == CMD_SET_ID) req_id_d = cmd_i.frame[31:24];
            end else if (st == ST_PENDING) begin
              // drop back to idle once the poll count passes the timeout
              if (tc_inc > reply_timeout_q) begin
                tmo_d[cmd_i.idx] = 8'd0;
                new_st           = ST_IDLE;
              end else begin
                tmo_d[cmd_i.idx] = tc_inc;
              end
            end else if (cmd_i.code == CMD_SET_ID && st == ST_ACKED) begin
              cur_id_d = req_id_q;
            end
            status_d[cmd_i.idx] = new_st;
          end
        end
        OP_REPLY: begin
          if (cmd_i.code_ok) begin
            unique case (cmd_i.code)
              CMD_READ_ANGLE: begin
                angle_d = cmd_i.value[15:0];
                new_st  = ST_ACKED;
              end
              CMD_READ_MULTI: begin
                pos_d  = cmd_i.value;
                new_st = ST_ACKED;
              end
              CMD_READ_TURN: begin
                turn_d = cmd_i.value[19:0];
                new_st = ST_ACKED;
              end
              CMD_READ_SPEED: begin
                speed_d = cmd_i.value;
                new_st  = ST_ACKED;
              end
              CMD_SET_ID: new_st = (cmd_i.rid == req_id_q) ? ST_ACKED : ST_REFUSED;
              default:    new_st = cmd_i.pay_ok ? ST_ACKED : ST_REFUSED;
            endcase
            status_d[cmd_i.idx] = new_st;
          end
          silence_d = 16'd0;
        end
        OP_TICK: begin
          if (silence_inc > {1'b0, offline_limit_q}) begin
            silence_d = offline_limit_q;
            online_d  = 1'b0;
          end else begin
            silence_d = silence_inc[15:0];
            online_d  = 1'b1;
          end
          if (cmd_i.code_ok) new_st = st;
        end
        default: begin
          if (cmd_i.code_ok) new_st = st;
        end
      endcase
    end

    res_d.tx_can_id           = cur_id_d;
    res_d.command_status      = new_st;
    res_d.angle_count         = angle_d;
    res_d.multi_turn_position = pos_d;
    res_d.turn_count          = turn_d;
    res_d.speed_word          = speed_d;
    res_d.online              = online_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COMMANDS; i++) begin
        status_q[i] <= ST_IDLE;
        tmo_q[i]    <= 8'd0;
      end
      offline_limit_q <= OFFLINE_LIMIT_RST;
      reply_timeout_q <= REPLY_TIMEOUT_RST;
      req_id_q        <= 8'd0;
      cur_id_q        <= DEVICE_ID_RST;
      angle_q         <= 16'd0;
      pos_q           <= 32'd0;
      turn_q          <= 20'd0;
      speed_q         <= 32'd0;
      silence_q       <= 16'd0;
      online_q        <= 1'b0;
      wr_ptr_q        <= 1'b0;
      rd_ptr_q        <= 1'b0;
      cnt_q           <= 2'd0;
    end else begin
      status_d_to_q: for (int i = 0; i < NUM_COMMANDS; i++) begin
        status_q[i] <= status_d[i];
        tmo_q[i]    <= tmo_d[i];
      end
      req_id_q  <= req_id_d;
      angle_q   <= angle_d;
      pos_q     <= pos_d;
      turn_q    <= turn_d;
      speed_q   <= speed_d;
      silence_q <= silence_d;
      online_q  <= online_d;
      // the user must write configuration only while idle (the block does not enforce it); it overrides the item path
      if (cfg_we_i && cfg_idx_i == CFG_OFFLINE_LIMIT) offline_limit_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_REPLY_TIMEOUT) reply_timeout_q <= cfg_data_i[7:0];
      if (cfg_we_i && cfg_idx_i == CFG_INITIAL_ID) cur_id_q <= cfg_id;
      else cur_id_q <= cur_id_d;
      if (exec) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, exec} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) res_q[wr_ptr_q] <= res_d;
  end

endmodule

### hdl/can_encoder_command_tracker_unit.sv
// CAN encoder command tracker, top level. Depends on cect_pkg, cect_front,
// cect_cmd_fifo and cect_back.
// Path: an accepted request enters the command queue; the back end then executes it into
// the result queue, from which it can be popped.
// Throughput: one request per cycle while neither queue is full; the back end executes
// each request against the per-command status and timeout registers.
// Reset (rst_ni low, asynchronous): all commands idle, counters and decoded values zero,
// device offline, configuration back to limit 100, timeout 100, identifier 1; both queues empty.
module can_encoder_command_tracker_unit import cect_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         command_code_i,
  input  logic [15:0]        argument_i,
  input  logic [7:0]         reply_id_i,
  input  logic [7:0]         reply_code_i,
  input  logic [31:0]        reply_payload_i,
  output logic               empty,
  input  logic               pop,
  output logic               send_valid_o,
  output logic [63:0]        tx_frame_o,
  output logic [7:0]         tx_can_id_o,
  output logic [1:0]         command_status_o,
  output logic [15:0]        angle_count_o,
  output logic signed [31:0] multi_turn_position_o,
  output logic signed [19:0] turn_count_o,
  output logic [31:0]        speed_word_o,
  output logic               online_o
);

  cmd_t front_cmd;
  cmd_t queued_cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res;

  cect_front u_front (
    .operation_i     (operation_i),
    .command_code_i  (command_code_i),
    .argument_i      (argument_i),
    .reply_id_i      (reply_id_i),
    .reply_code_i    (reply_code_i),
    .reply_payload_i (reply_payload_i),
    .cmd_o           (front_cmd)
  );

  cect_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (queued_cmd),
    .empty_o (cmd_empty)
  );

  cect_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (queued_cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign send_valid_o          = res.send_valid;
  assign tx_frame_o            = res.tx_frame;
  assign tx_can_id_o           = res.tx_can_id;
  assign command_status_o      = res.command_status;
  assign angle_count_o         = res.angle_count;
  assign multi_turn_position_o = res.multi_turn_position;
  assign turn_count_o          = res.turn_count;
  assign speed_word_o          = res.speed_word;
  assign online_o              = res.online;

endmodule

### dv/can_encoder_command_tracker_unit_tb.sv
// Self-checking bench for the CAN encoder command tracker: request, reply and tick
// items go in through the push/full queue and every popped result is checked
// against a tracker model kept in the bench. Depends on cect_pkg and the RTL top.
module can_encoder_command_tracker_unit_tb;
  import cect_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;

  localparam logic [3:0] NO_CMD         = 4'd0;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  code;
    logic [15:0] arg;
    logic [7:0]  rid;
    logic [7:0]  rcode;
    logic [31:0] pay;
  } enc_item_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_idx_i       = CFG_OFFLINE_LIMIT;
  logic [15:0] cfg_data_i      = '0;
  logic        push            = 1'b0;
  logic        full;
  logic [1:0]  operation_i     = OP_NONE;
  logic [3:0]  command_code_i  = NO_CMD;
  logic [15:0] argument_i      = '0;
  logic [7:0]  reply_id_i      = '0;
  logic [7:0]  reply_code_i    = '0;
  logic [31:0] reply_payload_i = '0;
  logic        empty;
  logic        pop             = 1'b0;
  logic        send_valid_o;
  logic [63:0] tx_frame_o;
  logic [7:0]  tx_can_id_o;
  logic [1:0]  command_status_o;
  logic [15:0] angle_count_o;
  logic [31:0] multi_turn_position_o;
  logic [19:0] turn_count_o;
  logic [31:0] speed_word_o;
  logic        online_o;

  can_encoder_command_tracker_unit u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .push                  (push),
    .full                  (full),
    .operation_i           (operation_i),
    .command_code_i        (command_code_i),
    .argument_i            (argument_i),
    .reply_id_i            (reply_id_i),
    .reply_code_i          (reply_code_i),
    .reply_payload_i       (reply_payload_i),
    .empty                 (empty),
    .pop                   (pop),
    .send_valid_o          (send_valid_o),
    .tx_frame_o            (tx_frame_o),
    .tx_can_id_o           (tx_can_id_o),
    .command_status_o      (command_status_o),
    .angle_count_o         (angle_count_o),
    .multi_turn_position_o (multi_turn_position_o),
    .turn_count_o          (turn_count_o),
    .speed_word_o          (speed_word_o),
    .online_o              (online_o)
  );

  // tracker model state and its copy of the registers
  logic [1:0]  cmd_state [NUM_COMMANDS];
  logic [7:0]  wait_cnt  [NUM_COMMANDS];
  logic [15:0] lim_offline;
  logic [7:0]  lim_reply;
  logic [7:0]  asked_id;
  logic [7:0]  live_id;
  logic [15:0] angle_m;
  logic [31:0] multi_m;
  logic [19:0] turn_m;
  logic [31:0] speed_m;
  logic [15:0] silent_ticks;
  logic        online_m;

  enc_item_t backlog[$];
  res_t      due_results[$];
  enc_item_t on_wire;
  res_t      want;
  logic [7:0] gen_id = 8'd1;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;
  int hold_left   = 0;
  int idle_cycles = 0;
  int n_queued    = 0;
  int phase_count = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_frames    = 0;
  int n_timeouts  = 0;
  int n_acks      = 0;
  int n_refusals  = 0;

  function automatic bit code_in_range(logic [7:0] c);
    return (c != 8'd0) && (int'(c) <= CODE_MAX);
  endfunction

  function automatic bit is_read_cmd(logic [3:0] c);
    return c == CMD_READ_ANGLE || c == CMD_READ_MULTI || c == CMD_READ_TURN ||
           c == CMD_READ_SPEED;
  endfunction

  function automatic logic [63:0] encode_request(logic [3:0] c, logic [15:0] arg);
    logic [7:0] len, b3, b4, b5, b6;
    len = LEN_SHORT;
    b3  = '0;
    b4  = '0;
    b5  = '0;
    b6  = '0;
    case (c)
      CMD_SET_ID:      b3 = (arg == 16'd0) ? 8'd1 : (arg > 16'd255) ? 8'd255 : arg[7:0];
      CMD_SET_BAUD:    b3 = (arg > 16'd4) ? 8'd4 : arg[7:0];
      CMD_SET_MODE:    b3 = (arg >= 16'd2) ? MODE_HIGH_BYTE : arg[7:0];
      CMD_SET_RX_TIME: begin
        len      = LEN_MID;
        {b4, b3} = (arg < RX_TIME_MIN) ? RX_TIME_MIN : arg;
      end
      CMD_SET_DIR:     b3 = (arg > 16'd255) ? 8'd255 : arg[7:0];
      CMD_SET_SAMPLE:  begin
        len      = LEN_MID;
        {b4, b3} = arg;
      end
      CMD_SET_VALUE:   begin
        len      = LEN_LONG;
        {b5, b6} = arg;
      end
      default: ;
    endcase
    return {8'h00, b6, b5, b4, b3, 4'h0, c, FRAME_TAG, len};
  endfunction

  task automatic model_reset();
    for (int i = 0; i < NUM_COMMANDS; i++) begin
      cmd_state[i] = ST_IDLE;
      wait_cnt[i]  = '0;
    end
    lim_offline  = OFFLINE_LIMIT_RST;
    lim_reply    = REPLY_TIMEOUT_RST;
    asked_id     = '0;
    live_id      = DEVICE_ID_RST;
    angle_m      = '0;
    multi_m      = '0;
    turn_m       = '0;
    speed_m      = '0;
    silent_ticks = '0;
    online_m     = 1'b0;
  endtask

  // advance the model by one request and return the result it owes
  function automatic res_t track_item(enc_item_t it);
    res_t        r;
    int          k;
    logic [1:0]  st;
    logic [16:0] next_ticks;
    longint      t, tmax;
    r    = '0;
    tmax = {44'h0, TURN_MAX};
    case (it.op)
      OP_REQUEST: if (code_in_range({4'h0, it.code})) begin
        k  = int'(it.code) - 1;
        st = cmd_state[k];
        if (is_read_cmd(it.code) ? (st != ST_PENDING) : (st == ST_IDLE)) begin
          r.tx_frame   = encode_request(it.code, it.arg);
          r.send_valid = 1'b1;
          if (it.code == CMD_SET_ID) asked_id = r.tx_frame[31:24];
          cmd_state[k] = ST_PENDING;
          n_frames++;
        end else if (st == ST_PENDING) begin
          wait_cnt[k] = wait_cnt[k] + 8'd1;
          if (wait_cnt[k] > lim_reply) begin
            wait_cnt[k]  = '0;
            cmd_state[k] = ST_IDLE;
            n_timeouts++;
          end
        end else if (it.code == CMD_SET_ID && st == ST_ACKED) begin
          live_id = asked_id;
        end
        r.command_status = cmd_state[k];
      end
      OP_REPLY: begin
        if (code_in_range(it.rcode)) begin
          k  = int'(it.rcode) - 1;
          st = (it.pay[7:0] == 8'h00) ? ST_ACKED : ST_REFUSED;
          case (it.rcode[3:0])
            CMD_READ_ANGLE: begin
              angle_m = it.pay[15:0];
              st      = ST_ACKED;
            end
            CMD_READ_MULTI: begin
              multi_m = (it.pay > MULTI_WRAP_LIMIT) ? it.pay - MULTI_WRAP_SUB : it.pay;
              st      = ST_ACKED;
            end
            CMD_READ_TURN: begin
              t = {32'h0, it.pay};
              if (it.pay > TURN_WRAP_LIMIT) t = t - tmax;
              if (t > tmax) t = tmax;
              else if (t < -tmax) t = -tmax;
              turn_m = t[19:0];
              st     = ST_ACKED;
            end
            CMD_READ_SPEED: begin
              speed_m = it.pay;
              st      = ST_ACKED;
            end
            CMD_SET_ID: st = (it.rid == asked_id) ? ST_ACKED : ST_REFUSED;
            default: ;
          endcase
          cmd_state[k]     = st;
          r.command_status = st;
          if (st == ST_ACKED) n_acks++;
          else n_refusals++;
        end
        silent_ticks = '0;
      end
      default: begin
        if (it.op == OP_TICK) begin
          next_ticks = {1'b0, silent_ticks} + 17'd1;
          if (next_ticks > {1'b0, lim_offline}) begin
            silent_ticks = lim_offline;
            online_m     = 1'b0;
          end else begin
            silent_ticks = next_ticks[15:0];
            online_m     = 1'b1;
          end
        end
        if (code_in_range({4'h0, it.code})) r.command_status = cmd_state[int'(it.code) - 1];
      end
    endcase
    r.tx_can_id           = live_id;
    r.angle_count         = angle_m;
    r.multi_turn_position = multi_m;
    r.turn_count          = turn_m;
    r.speed_word          = speed_m;
    r.online              = online_m;
    return r;
  endfunction

  // request construction; fields that the operation ignores carry noise
  function automatic enc_item_t scrambled();
    enc_item_t it;
    it.op    = OP_NONE;
    it.code  = 4'($urandom());
    it.arg   = 16'($urandom());
    it.rid   = 8'($urandom());
    it.rcode = 8'($urandom());
    it.pay   = $urandom();
    return it;
  endfunction

  function automatic logic [15:0] pick_arg();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 6));
      3:       return 16'($urandom_range(45, 300));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] pick_payload();
    logic [31:0] p;
    p = $urandom();
    case ($urandom_range(0, 5))
      0, 1: p[7:0] = 8'h00;
      2: begin
        case ($urandom_range(0, 2))
          0:       p = MULTI_WRAP_LIMIT;
          1:       p = TURN_WRAP_LIMIT;
          default: p = TURN_SAT_LIMIT;
        endcase
        p = p + 32'($urandom_range(0, 2)) - 32'd1;
      end
      3: p = 32'($urandom_range(0, 1100000));
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] pick_read_code();
    case ($urandom_range(0, 3))
      0:       return CMD_READ_ANGLE;
      1:       return CMD_READ_MULTI;
      2:       return CMD_READ_TURN;
      default: return CMD_READ_SPEED;
    endcase
  endfunction

  task automatic add_item(enc_item_t it, bit counted);
    backlog.push_back(it);
    n_queued++;
    if (counted) phase_count++;
  endtask

  task automatic queue_request(logic [3:0] code, logic [15:0] arg);
    enc_item_t   it;
    logic [63:0] frame;
    it      = scrambled();
    it.op   = OP_REQUEST;
    it.code = code;
    it.arg  = arg;
    if (code == CMD_SET_ID) begin
      frame  = encode_request(code, arg);
      gen_id = frame[31:24];
    end
    add_item(it, code_in_range({4'h0, code}));
  endtask

  task automatic queue_reply(logic [7:0] rcode, logic [7:0] rid, logic [31:0] pay);
    enc_item_t it;
    it       = scrambled();
    it.op    = OP_REPLY;
    it.rcode = rcode;
    it.rid   = rid;
    it.pay   = pay;
    add_item(it, 1'b1);
  endtask

  task automatic queue_tick(logic [1:0] op, logic [3:0] code);
    enc_item_t it;
    it      = scrambled();
    it.op   = op;
    it.code = code;
    add_item(it, 1'b1);
  endtask

  // issue, sometimes one to eight polls, often the answer and possibly a follow-up request
  task automatic queue_exchange(bit any_reply);
    logic [3:0] c;
    logic [7:0] rid;
    c = 4'($urandom_range(1, CODE_MAX));
    queue_request(c, pick_arg());
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) queue_request(c, pick_arg());
    if ((any_reply || is_read_cmd(c)) && $urandom_range(0, 7) != 0) begin
      rid = ($urandom_range(0, 3) != 0) ? gen_id : 8'($urandom());
      queue_reply({4'h0, c}, rid, pick_payload());
      if ($urandom_range(0, 1)) queue_request(c, pick_arg());
    end
    if ($urandom_range(0, 3) == 0) queue_tick(OP_TICK, c);
  endtask

  task automatic queue_random(int n_items, bit any_reply);
    int         pick;
    logic [3:0] c;
    phase_count = 0;
    while (phase_count < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_exchange(any_reply);
      end else if (pick < 70) begin
        queue_request(4'($urandom_range(1, CODE_MAX)), pick_arg());
      end else if (pick < 82) begin
        queue_tick(OP_TICK, 4'($urandom()));
      end else if (pick < 86) begin
        queue_tick(OP_NONE, 4'($urandom()));
      end else if (pick < 93) begin
        c = any_reply ? 4'($urandom_range(1, CODE_MAX)) : pick_read_code();
        queue_reply({4'h0, c}, 8'($urandom()), pick_payload());
      end else if ($urandom_range(0, 1)) begin
        c = ($urandom_range(0, 2) == 0) ? NO_CMD : 4'($urandom_range(CODE_MAX + 1, 15));
        queue_request(c, pick_arg());
      end else begin
        queue_reply(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(CODE_MAX + 1, 255)),
                    8'($urandom()), $urandom());
      end
    end
  endtask

  task automatic queue_directed();
    queue_request(CMD_READ_ANGLE, 16'd0);
    queue_request(CMD_READ_ANGLE, 16'd0);      // poll past a zero timeout: back to idle
    queue_request(CMD_SET_ID, 16'd0);
    queue_request(CMD_SET_BAUD, 16'hFFFF);
    queue_request(CMD_SET_MODE, 16'd2);
    queue_request(CMD_SET_RX_TIME, 16'd0);
    queue_request(CMD_SET_ZERO, 16'h1234);
    queue_request(CMD_SET_DIR, 16'd300);
    queue_request(CMD_READ_MULTI, 16'd0);
    queue_request(CMD_READ_TURN, 16'd0);
    queue_request(CMD_READ_SPEED, 16'd0);
    queue_request(CMD_SET_SAMPLE, 16'hBEEF);
    queue_request(CMD_SET_MID, 16'd0);
    queue_request(CMD_SET_VALUE, 16'hA5C3);
    queue_reply({4'h0, CMD_READ_MULTI}, 8'd0, 32'hFFFF_FFFF);
    queue_reply({4'h0, CMD_READ_TURN}, 8'd0, 32'hFFFF_FFFF);
    queue_reply({4'h0, CMD_READ_TURN}, 8'd0, 32'h0004_0000);
    queue_reply({4'h0, CMD_READ_ANGLE}, 8'd0, 32'hFFFF_FFFF);
    queue_reply({4'h0, CMD_SET_ID}, 8'd1, 32'h0000_00FF);
    queue_request(CMD_SET_ID, 16'd0);          // acked set id: switch identifier
    queue_reply({4'h0, CMD_SET_BAUD}, 8'd0, 32'h0000_0001);
    queue_request(4'd15, 16'hFFFF);
    queue_reply(8'd200, 8'hFF, 32'h0000_0000);
    queue_tick(OP_TICK, CMD_SET_BAUD);
    queue_tick(OP_NONE, NO_CMD);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_OFFLINE_LIMIT: lim_offline = val;
      CFG_REPLY_TIMEOUT: lim_reply = val[7:0];
      CFG_INITIAL_ID:    live_id = (val[7:0] == 8'd0) ? 8'd1 : val[7:0];
      default: ;
    endcase
  endtask

  // hold until every queued request has produced its checked result
  task automatic drain();
    while (n_checked < n_queued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic compare_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
      n_errors++;
    end
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver: hold a request while full, otherwise offer the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        due_results.push_back(track_item(on_wire));
        n_accepted++;
      end
      if (!(push && full)) begin
        if (backlog.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          on_wire = backlog.pop_front();
          push            <= 1'b1;
          operation_i     <= on_wire.op;
          command_code_i  <= on_wire.code;
          argument_i      <= on_wire.arg;
          reply_id_i      <= on_wire.rid;
          reply_code_i    <= on_wire.rcode;
          reply_payload_i <= on_wire.pay;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor: check the popped result, then decide whether to pop next cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        n_checked++;
        if (due_results.size() == 0) begin
          $display("%0t: result popped with nothing expected", $time);
          n_errors++;
        end else begin
          want = due_results.pop_front();
          compare_field("send_valid", want.send_valid, send_valid_o);
          compare_field("tx_frame", want.tx_frame, tx_frame_o);
          compare_field("tx_can_id", want.tx_can_id, tx_can_id_o);
          compare_field("command_status", want.command_status, command_status_o);
          compare_field("angle_count", want.angle_count, angle_count_o);
          compare_field("multi_turn_position", want.multi_turn_position,
                        multi_turn_position_o);
          compare_field("turn_count", want.turn_count, turn_count_o);
          compare_field("speed_word", want.speed_word, speed_word_o);
          compare_field("online", want.online, online_o);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (hold_req != 0) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    model_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 9;
    rx_idle_pct = 78;
    write_reg(CFG_REPLY_TIMEOUT, 16'd0);
    write_reg(CFG_OFFLINE_LIMIT, 16'd3);
    write_reg(CFG_INITIAL_ID, 16'hFF00);       // zero identifier saturates to one
    queue_directed();
    queue_random(350, 1'b0);
    drain();

    tx_idle_pct = 78;
    rx_idle_pct = 9;
    write_reg(CFG_OFFLINE_LIMIT, 16'd0);
    write_reg(CFG_REPLY_TIMEOUT, 16'd5);
    write_reg(CFG_INITIAL_ID, 16'h00FF);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    queue_random(350, 1'b0);
    drain();

    // stall the receiver while the backlog is deep so the block fills up
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_OFFLINE_LIMIT, 16'hFFFF);
    write_reg(CFG_REPLY_TIMEOUT, 16'd255);
    write_reg(CFG_INITIAL_ID, 16'h375A);
    queue_random(450, 1'b1);
    hold_req = 1;
    drain();

    write_reg(CFG_OFFLINE_LIMIT, 16'd6);
    write_reg(CFG_REPLY_TIMEOUT, 16'd254);
    write_reg(CFG_INITIAL_ID, 16'($urandom_range(1, 255)));
    queue_random(400, 1'b1);
    drain();

    $display("tb: %0d requests over four register settings, %0d results compared",
             n_accepted, n_checked);
    $display("tb: %0d frames built, %0d timeouts, %0d acks, %0d refusals",
             n_frames, n_timeouts, n_acks, n_refusals);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### can_encoder_command_tracker_unit.f
hdl/cect_pkg.sv
hdl/cect_front.sv
hdl/cect_cmd_fifo.sv
hdl/cect_back.sv
hdl/can_encoder_command_tracker_unit.sv
dv/can_encoder_command_tracker_unit_tb.sv
